>>> hw/rtl/irpd_pkg.sv
// Shared types, constants and helpers of the icon row pixel decoder.
package irpd_pkg;

  localparam int MAX_ROW_PIXELS = 1024;
  localparam int PALETTE_DEPTH  = 256;
  localparam int QUEUE_DEPTH    = 4;

  localparam int POS_W  = $clog2(MAX_ROW_PIXELS + 1);
  localparam int LS_AW  = $clog2(MAX_ROW_PIXELS);
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // input commands
  localparam logic [1:0] CMD_PALETTE = 2'd0;
  localparam logic [1:0] CMD_COLOUR  = 2'd1;
  localparam logic [1:0] CMD_MASK    = 2'd2;

  // pixel formats
  localparam logic [2:0] FMT_2BPP = 3'd0;
  localparam logic [2:0] FMT_4BPP = 3'd1;
  localparam logic [2:0] FMT_8BPP = 3'd2;
  localparam logic [2:0] FMT_BGR  = 3'd3;
  localparam logic [2:0] FMT_BGRA = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 1'd1;
  localparam int CFG_DATA_W = 11;

  localparam logic [2:0]  FMT_RESET       = FMT_8BPP;
  localparam logic [10:0] ROW_WIDTH_RESET = 11'd1024;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_bgr;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [9:0] pixel_x;
    logic       last_in_row;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_PAL,
    OP_COLOUR,
    OP_MASK
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_bgr;
  } op_t;

  // row_width of zero acts as one, anything above the line store acts as its size
  function automatic logic [POS_W-1:0] eff_width(input logic [10:0] rw);
    logic [POS_W-1:0] w;
    if (rw == 11'd0) begin
      w = POS_W'(1);
    end else if (32'(rw) > MAX_ROW_PIXELS) begin
      w = POS_W'(MAX_ROW_PIXELS);
    end else begin
      w = POS_W'(rw);
    end
    return w;
  endfunction

  function automatic logic pal_in_range(input logic [7:0] idx);
    return (32'(idx) < PALETTE_DEPTH);
  endfunction

endpackage

>>> hw/rtl/irpd_front.sv
// Front end: takes input transfers, classifies the command and feeds the op queue.
module irpd_front import irpd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output op_t      push_op,
  input  logic     q_full
);

  logic op_valid_r, op_valid_nxt;
  op_t  op_r, op_nxt;
  logic take;
  logic known;
  op_kind_t kind;

  assign push     = op_valid_r && !q_full;
  assign push_op  = op_r;
  assign in_stall = op_valid_r && q_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    known = 1'b1;
    kind  = OP_PAL;
    unique case (in_data.command)
      CMD_PALETTE: kind = OP_PAL;
      CMD_COLOUR:  kind = OP_COLOUR;
      CMD_MASK:    kind = OP_MASK;
      default:     known = 1'b0;  // unknown command is dropped here
    endcase
  end

  always_comb begin
    op_valid_nxt = op_valid_r && !push;
    op_nxt       = op_r;
    if (take && known) begin
      op_valid_nxt         = 1'b1;
      op_nxt.kind          = kind;
      op_nxt.data_byte     = in_data.data_byte;
      op_nxt.palette_index = in_data.palette_index;
      op_nxt.palette_bgr   = in_data.palette_bgr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= op_valid_nxt;
    end
    op_r <= op_nxt;
  end

endmodule

>>> hw/rtl/irpd_queue.sv
// Short op queue between front end and back end.
module irpd_queue import irpd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

>>> hw/rtl/irpd_back.sv
// Back end: palette and line stores, colour unpacking, mask pass and pixel output.
module irpd_back import irpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  head_valid,
  input  op_t                   head_op,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  // configuration
  logic [2:0]       fmt_r;
  logic [POS_W-1:0] eff_w_r;

  // row state
  logic [POS_W-1:0] col_pos_r, col_pos_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [23:0]      partial_r, partial_nxt;
  logic [POS_W-1:0] mask_pos_r, mask_pos_nxt;
  logic [2:0]       sub_r, sub_nxt;

  // stores
  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [31:0] line_mem [MAX_ROW_PIXELS];
  logic [23:0] pal_rd_r;
  logic [31:0] line_rd_r;

  // line store write stage
  logic             wr_valid_r, wr_valid_nxt;
  logic [LS_AW-1:0] wr_addr_r, wr_addr_nxt;
  logic             wr_pal_r, wr_pal_nxt;
  logic             wr_pal_ok_r, wr_pal_ok_nxt;
  logic [31:0]      wr_word_r, wr_word_nxt;
  logic [31:0]      line_wdata;

  // line store read stage
  logic       rd_valid_r, rd_valid_nxt;
  logic [9:0] rd_x_r, rd_x_nxt;
  logic       rd_last_r, rd_last_nxt;
  logic       rd_clear_r, rd_clear_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic              pal_we, pal_re, line_re;
  logic [PAL_AW-1:0] pal_raddr;
  logic [LS_AW-1:0]  line_raddr;
  logic              rd_move, rd_free;
  logic [7:0]        sh2, sh4, shm;
  logic [7:0]        idx;
  logic              idx_last;
  logic              mask_last;
  logic [7:0]        b;

  assign b         = head_op.data_byte;
  assign rd_move   = rd_valid_r && (!out_valid_r || !out_stall);
  assign rd_free   = !rd_valid_r || rd_move;
  assign sh2       = b << {sub_r, 1'b0};
  assign sh4       = b << {sub_r, 2'b00};
  assign shm       = b << sub_r;
  assign mask_last = (POS_W'(mask_pos_r + 1'b1) == eff_w_r);

  always_comb begin
    idx      = b;
    idx_last = 1'b1;
    unique case (fmt_r)
      FMT_2BPP: begin
        idx      = {6'b0, sh2[7:6]};
        idx_last = (sub_r == 3'd3);
      end
      FMT_4BPP: begin
        idx      = {4'b0, sh4[7:4]};
        idx_last = (sub_r == 3'd1);
      end
      default: begin
        idx      = b;
        idx_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    col_pos_nxt   = col_pos_r;
    phase_nxt     = phase_r;
    partial_nxt   = partial_r;
    mask_pos_nxt  = mask_pos_r;
    sub_nxt       = sub_r;
    pop           = 1'b0;
    pal_we        = 1'b0;
    pal_re        = 1'b0;
    pal_raddr     = PAL_AW'(idx);
    line_re       = 1'b0;
    line_raddr    = LS_AW'(mask_pos_r);
    wr_valid_nxt  = 1'b0;
    wr_addr_nxt   = LS_AW'(col_pos_r);
    wr_pal_nxt    = 1'b0;
    wr_pal_ok_nxt = pal_in_range(idx);
    wr_word_nxt   = {8'hff, b, partial_r[15:0]};
    rd_valid_nxt  = rd_valid_r && !rd_move;
    rd_x_nxt      = 10'(mask_pos_r);
    rd_last_nxt   = mask_last;
    rd_clear_nxt  = shm[7];

    if (head_valid) begin
      unique case (head_op.kind)
        OP_PAL: begin
          pal_we = pal_in_range(head_op.palette_index);
          pop    = 1'b1;
        end
        OP_COLOUR: begin
          if (col_pos_r >= eff_w_r) begin
            // row full: byte dropped, remaining indices would be dropped too
            pop     = 1'b1;
            sub_nxt = '0;
          end else if (fmt_r == FMT_2BPP || fmt_r == FMT_4BPP || fmt_r == FMT_8BPP) begin
            pal_re       = 1'b1;
            wr_valid_nxt = 1'b1;
            wr_pal_nxt   = 1'b1;
            col_pos_nxt  = col_pos_r + 1'b1;
            if (idx_last) begin
              pop     = 1'b1;
              sub_nxt = '0;
            end else begin
              sub_nxt = sub_r + 1'b1;
            end
          end else if (fmt_r == FMT_BGR) begin
            pop = 1'b1;
            if (phase_r >= 2'd2) begin
              wr_valid_nxt = 1'b1;
              wr_word_nxt  = {8'hff, b, partial_r[15:0]};
              col_pos_nxt  = col_pos_r + 1'b1;
              phase_nxt    = '0;
              partial_nxt  = '0;
            end else begin
              partial_nxt = partial_r | ({16'b0, b} << {phase_r, 3'b000});
              phase_nxt   = phase_r + 1'b1;
            end
          end else if (fmt_r == FMT_BGRA) begin
            pop = 1'b1;
            if (phase_r == 2'd3) begin
              wr_valid_nxt = 1'b1;
              wr_word_nxt  = {b, partial_r};
              col_pos_nxt  = col_pos_r + 1'b1;
              phase_nxt    = '0;
              partial_nxt  = '0;
            end else begin
              partial_nxt = partial_r | ({16'b0, b} << {phase_r, 3'b000});
              phase_nxt   = phase_r + 1'b1;
            end
          end else begin
            pop = 1'b1;  // undefined format ignores colour bytes
          end
        end
        OP_MASK: begin
          if (mask_pos_r >= eff_w_r) begin
            // stale mask byte past row end: restart the row, no pixels
            pop          = 1'b1;
            sub_nxt      = '0;
            col_pos_nxt  = '0;
            phase_nxt    = '0;
            partial_nxt  = '0;
            mask_pos_nxt = '0;
          end else if (rd_free && !wr_valid_r) begin
            line_re      = 1'b1;
            rd_valid_nxt = 1'b1;
            if (mask_last) begin
              pop          = 1'b1;
              sub_nxt      = '0;
              col_pos_nxt  = '0;
              phase_nxt    = '0;
              partial_nxt  = '0;
              mask_pos_nxt = '0;
            end else begin
              mask_pos_nxt = mask_pos_r + 1'b1;
              if (sub_r == 3'd7) begin
                pop     = 1'b1;
                sub_nxt = '0;
              end else begin
                sub_nxt = sub_r + 1'b1;
              end
            end
          end
        end
        default: pop = 1'b1;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (rd_move) begin
      out_valid_nxt       = 1'b1;
      out_nxt.red         = line_rd_r[23:16];
      out_nxt.green       = line_rd_r[15:8];
      out_nxt.blue        = line_rd_r[7:0];
      out_nxt.alpha       = rd_clear_r ? 8'h00 : line_rd_r[31:24];
      out_nxt.pixel_x     = rd_x_r;
      out_nxt.last_in_row = rd_last_r;
    end
  end

  assign line_wdata = wr_pal_r ? {8'hff, (wr_pal_ok_r ? pal_rd_r : 24'h0)} : wr_word_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= FMT_RESET;
      eff_w_r     <= eff_width(ROW_WIDTH_RESET);
      col_pos_r   <= '0;
      phase_r     <= '0;
      partial_r   <= '0;
      mask_pos_r  <= '0;
      sub_r       <= '0;
      wr_valid_r  <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_PIXEL_FORMAT: fmt_r   <= cfg_wdata[2:0];
          REG_ROW_WIDTH:    eff_w_r <= eff_width(cfg_wdata);
          default: ;
        endcase
      end
      col_pos_r   <= col_pos_nxt;
      phase_r     <= phase_nxt;
      partial_r   <= partial_nxt;
      mask_pos_r  <= mask_pos_nxt;
      sub_r       <= sub_nxt;
      wr_valid_r  <= wr_valid_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wr_addr_r   <= wr_addr_nxt;
    wr_pal_r    <= wr_pal_nxt;
    wr_pal_ok_r <= wr_pal_ok_nxt;
    wr_word_r   <= wr_word_nxt;
    if (line_re) begin
      rd_x_r     <= rd_x_nxt;
      rd_last_r  <= rd_last_nxt;
      rd_clear_r <= rd_clear_nxt;
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[PAL_AW'(head_op.palette_index)] <= head_op.palette_bgr;
    end
    if (pal_re) begin
      pal_rd_r <= pal_mem[pal_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid_r) begin
      line_mem[wr_addr_r] <= line_wdata;
    end
    if (line_re) begin
      line_rd_r <= line_mem[line_raddr];
    end
  end

  // mask reads never overlap a pending line store write
  assert property (@(posedge clk) disable iff (!rst_n) line_re |-> !wr_valid_r)
    else $error("line store read during pending write");

  // a stalled read stage keeps its pixel
  assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid_r && out_valid_r && out_stall |=> rd_valid_r && $stable(line_rd_r))
    else $error("read stage lost a pixel under stall");

  // a palette lookup is always followed by its line store write
  assert property (@(posedge clk) disable iff (!rst_n) pal_re |=> wr_valid_r && wr_pal_r)
    else $error("palette lookup without line store write");

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    32'(mask_pos_r) < MAX_ROW_PIXELS)
    else $error("mask position beyond line store");

endmodule

>>> hw/rtl/icon_row_pixel_decoder.sv
// Top level of the icon row pixel decoder.
//
//   channel | dir | handshake           | payload
//   in      | in  | in_valid / in_stall | in_item_t: command, data byte, palette entry
//   out     | out | out_valid/out_stall | out_item_t: RGBA, pixel_x, last_in_row
//   cfg     | in  | cfg_wr_en           | cfg_index, cfg_wdata (pixel_format, row_width)
//
// The front end takes one transfer a cycle while the four-entry op queue has room.
// Back end: palette writes and 24/32-bit colour bytes pop at once; palette colour
// bytes give one index per cycle (4, 2 or 1), set by the single palette read port;
// mask bytes one pixel per cycle (up to 8) unless held by out_stall or a pending
// write, set by the single line store read port and the one-pixel output register.
// Reset (rst_n low, synchronous) clears control state, resets config; stores are not
// cleared. out_stall holds the output register and read stage without losing pixels.
module icon_row_pixel_decoder import irpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic push, q_full, pop, head_valid;
  op_t  push_op, head_op;

  irpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_op  (push_op),
    .q_full   (q_full)
  );

  irpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  irpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> sim/icon_row_pixel_decoder_test.sv
// Self-checking testbench for the icon row pixel decoder: predicted pixels vs. DUT output.
module icon_row_pixel_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import irpd_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 100;
  localparam int         DRAIN_CYCLES = 48;
  localparam int         MAX_REPORTS  = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PIXEL_FORMAT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  icon_row_pixel_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder image: stores, row state and registers
  logic [23:0]  pal_mem [PALETTE_DEPTH];
  logic [31:0]  line_mem [MAX_ROW_PIXELS];
  int unsigned  fill_pos = 0;
  int unsigned  phase = 0;
  int unsigned  mask_pos = 0;
  logic [23:0]  partial = '0;
  logic [2:0]   fmt = FMT_RESET;
  logic [10:0]  width_reg = ROW_WIDTH_RESET;

  out_item_t    pending_pixels[$];
  int unsigned  mismatches = 0;
  int unsigned  counted_items = 0;
  int unsigned  burst_left = 0;
  int unsigned  stall_mode = 0;
  int unsigned  stall_left = 0;

  function automatic int unsigned span_of(logic [10:0] w);
    if (w == 11'd0) return 1;
    if (int'(w) > MAX_ROW_PIXELS) return MAX_ROW_PIXELS;
    return 32'(w);
  endfunction

  function automatic int unsigned colour_bytes(logic [2:0] f, int unsigned span);
    case (f)
      FMT_2BPP: return (span + 3) / 4;
      FMT_4BPP: return (span + 1) / 2;
      FMT_8BPP: return span;
      FMT_BGR:  return 3 * span;
      FMT_BGRA: return 4 * span;
      default:  return $urandom_range(1, 4);
    endcase
  endfunction

  function automatic void restart_row();
    fill_pos = 0;
    phase    = 0;
    partial  = '0;
    mask_pos = 0;
  endfunction

  function automatic void store_pixel(logic [31:0] rgba);
    if (fill_pos < span_of(width_reg)) begin
      line_mem[fill_pos] = rgba;
      fill_pos++;
    end
  endfunction

  function automatic void unpack_colour(logic [7:0] b);
    int unsigned bpp;
    int unsigned idx;
    if (fill_pos >= span_of(width_reg)) return;
    case (fmt)
      FMT_2BPP, FMT_4BPP, FMT_8BPP: begin
        bpp = 2 << fmt;
        for (int k = 0; k < 8 / bpp; k++) begin
          idx = (b >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
          store_pixel({8'hff, pal_mem[idx]});
        end
      end
      FMT_BGR: begin
        // a phase left over from BGRA mode also completes the pixel
        if (phase >= 2) begin
          store_pixel({8'hff, b, partial[15:0]});
          phase   = 0;
          partial = '0;
        end else begin
          partial = partial | (24'(b) << (8 * phase));
          phase++;
        end
      end
      FMT_BGRA: begin
        if (phase >= 3) begin
          store_pixel({b, partial});
          phase   = 0;
          partial = '0;
        end else begin
          partial = partial | (24'(b) << (8 * phase));
          phase++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void emit_mask(logic [7:0] b);
    int unsigned span;
    logic [31:0] px;
    out_item_t   p;
    span = span_of(width_reg);
    if (mask_pos >= span) begin
      restart_row();
      return;
    end
    for (int k = 0; k < 8; k++) begin
      px            = line_mem[mask_pos % MAX_ROW_PIXELS];
      p.red         = px[23:16];
      p.green       = px[15:8];
      p.blue        = px[7:0];
      p.alpha       = b[7-k] ? 8'h00 : px[31:24];
      p.pixel_x     = 10'(mask_pos);
      p.last_in_row = (mask_pos + 1 == span);
      pending_pixels = {pending_pixels, p};
      if (p.last_in_row) begin
        restart_row();
        break;
      end
      mask_pos++;
    end
  endfunction

  function automatic void predict_transfer(in_item_t it);
    case (it.command)
      CMD_PALETTE: begin
        if (int'(it.palette_index) < PALETTE_DEPTH) pal_mem[it.palette_index] = it.palette_bgr;
      end
      CMD_COLOUR:  unpack_colour(it.data_byte);
      CMD_MASK:    emit_mask(it.data_byte);
      default: ;
    endcase
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, logic [7:0] b);
    in_item_t it;
    it.command       = cmd;
    it.data_byte     = b;
    it.palette_index = 8'($urandom);
    it.palette_bgr   = 24'($urandom);
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    // predicting ahead is safe: the payload is held until it is taken
    predict_transfer(it);
    if (!(it.command == CMD_UNUSED || (it.command == CMD_COLOUR && fmt > FMT_BGRA)))
      counted_items++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_colour(logic [7:0] b);
    send_item(make_item(CMD_COLOUR, b));
  endtask

  task automatic send_mask(logic [7:0] b);
    send_item(make_item(CMD_MASK, b));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_PIXEL_FORMAT) fmt = val[2:0];
    else width_reg = val[10:0];
    @(posedge clk);
  endtask

  // upper bits of the format write are junk the block must drop
  task automatic set_format(logic [2:0] f, logic [10:0] w);
    wait_idle();
    write_reg(REG_PIXEL_FORMAT, {8'($urandom), f});
    write_reg(REG_ROW_WIDTH, w);
  endtask

  // result side
  task automatic compare_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_pixel(out_item_t got);
    out_item_t want;
    if (pending_pixels.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: pixel expected none actual x=%0d rgba=%h%h%h%h last=%0b", $time,
                 got.pixel_x, got.red, got.green, got.blue, got.alpha, got.last_in_row);
      mismatches++;
    end else begin
      want = pending_pixels.pop_front();
      compare_field("red", 10'(want.red), 10'(got.red));
      compare_field("green", 10'(want.green), 10'(got.green));
      compare_field("blue", 10'(want.blue), 10'(got.blue));
      compare_field("alpha", 10'(want.alpha), 10'(got.alpha));
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("last_in_row", 10'(want.last_in_row), 10'(got.last_in_row));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_pixel(out_data);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  // tests

  // every entry gets written, so no later read hits an unwritten one
  task automatic test_palette_load();
    in_item_t it;
    for (int i = 0; i < PALETTE_DEPTH; i++) begin
      it = make_item(CMD_PALETTE, 8'($urandom));
      it.palette_index = 8'(i);
      if (i == 0) it.palette_bgr = '0;
      else if (i == PALETTE_DEPTH - 1) it.palette_bgr = '1;
      send_item(it);
    end
  endtask

  // reset config: 8bpp, full width; the row is cut short by lowering the width
  task automatic test_reset_row();
    repeat (16) send_colour(8'($urandom));
    repeat (2) send_mask(8'($urandom));
    set_format(FMT_8BPP, 11'd4);
    send_mask(8'($urandom));
  endtask

  task automatic test_index_formats();
    set_format(FMT_2BPP, 11'd8);
    send_colour(8'h1b);
    send_colour(8'he4);
    send_mask(8'h00);
    set_format(FMT_4BPP, 11'd8);
    send_colour(8'h00);
    send_colour(8'hff);
    send_colour(8'h0f);
    send_colour(8'hf0);
    send_mask(8'hff);
    set_format(FMT_8BPP, 11'd8);
    send_colour(8'h00);
    send_colour(8'hff);
    send_colour(8'h01);
    send_colour(8'h80);
    send_colour(8'h7f);
    send_colour(8'hfe);
    send_colour(8'h55);
    send_colour(8'haa);
    send_mask(8'h5a);
  endtask

  task automatic test_direct_formats();
    set_format(FMT_BGR, 11'd2);
    repeat (3) send_colour(8'h00);
    repeat (3) send_colour(8'hff);
    send_mask(8'h40);
    set_format(FMT_BGRA, 11'd2);
    send_colour(8'h12);
    send_colour(8'h34);
    send_colour(8'h56);
    send_colour(8'h00);
    repeat (4) send_colour(8'hff);
    send_mask(8'h80);
  endtask

  task automatic test_width_limits();
    // zero width acts as one; the second byte lands past the row end
    set_format(FMT_8BPP, 11'd0);
    send_colour(8'h3c);
    send_colour(8'hc3);
    send_mask(8'h80);
    // odd width: low index of the last byte falls off the row
    set_format(FMT_4BPP, 11'd9);
    repeat (5) send_colour(8'($urandom));
    send_mask(8'hff);
    send_mask(8'h00);
    // oversized width clamps to the line store size: the row takes 1024 pixels and
    // drops the next byte, which would otherwise land on entry 0
    set_format(FMT_2BPP, 11'h7ff);
    repeat (MAX_ROW_PIXELS / 4 + 1) send_colour(8'($urandom));
    set_format(FMT_2BPP, 11'd8);
    send_mask(8'($urandom));
  endtask

  task automatic test_phase_carry();
    set_format(FMT_BGRA, 11'd4);
    send_colour(8'h11);
    send_colour(8'h22);
    send_colour(8'h33);
    set_format(FMT_BGR, 11'd4);
    send_colour(8'h44);
    repeat (9) send_colour(8'($urandom));
    send_mask(8'hf0);
  endtask

  task automatic test_undefined_codes();
    for (int f = int'(FMT_BGRA) + 1; f < 8; f++) begin
      set_format(3'(f), 11'd3);
      send_colour(8'($urandom));
      send_item(make_item(CMD_UNUSED, 8'($urandom)));
      send_colour(8'($urandom));
      send_mask(8'h20);
    end
  endtask

  task automatic test_mask_past_end();
    set_format(FMT_8BPP, 11'd16);
    repeat (16) send_colour(8'($urandom));
    send_mask(8'h01);
    // width drops below mask position: mask byte only restarts the row
    set_format(FMT_8BPP, 11'd4);
    send_mask(8'hff);
    repeat (4) send_colour(8'($urandom));
    send_mask(8'h0f);
  endtask

  task automatic add_noise();
    in_item_t it;
    case ($urandom_range(0, 29))
      0: begin
        it = make_item(CMD_PALETTE, 8'($urandom));
        send_item(it);
      end
      1: send_item(make_item(CMD_UNUSED, 8'($urandom)));
      default: ;
    endcase
  endtask

  task automatic random_row();
    logic [2:0]  f;
    logic [10:0] w;
    logic [7:0]  m;
    int unsigned span;
    int unsigned n_colour;
    int unsigned n_mask;
    int unsigned pick;
    f = fmt;
    w = width_reg;
    // some rows keep the config and follow the previous one without a pause
    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) f = 3'($urandom_range(int'(FMT_BGRA) + 1, 7));
      else f = 3'($urandom_range(FMT_2BPP, FMT_BGRA));
      pick = $urandom_range(0, 99);
      if (pick < 10) w = 11'($urandom_range(0, 1));
      else w = 11'($urandom_range(2, 40));
      set_format(f, w);
    end
    span = span_of(w);
    n_colour = colour_bytes(f, span);
    if ($urandom_range(0, 7) == 0) n_colour = $urandom_range(0, n_colour + 3);
    n_mask = (span + 7) / 8;
    if ($urandom_range(0, 7) == 0) n_mask = $urandom_range(0, n_mask + 2);
    repeat (n_colour) begin
      add_noise();
      send_colour(8'($urandom));
    end
    repeat (n_mask) begin
      add_noise();
      case ($urandom_range(0, 3))
        0:       m = 8'h00;
        1:       m = 8'hff;
        default: m = 8'($urandom);
      endcase
      send_mask(m);
    end
  endtask

  task automatic test_random();
    int unsigned start;
    start = counted_items;
    while (counted_items - start < RANDOM_ITEMS) random_row();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_palette_load();
    test_reset_row();
    test_index_formats();
    test_direct_formats();
    test_width_limits();
    test_phase_carry();
    test_undefined_codes();
    test_mask_past_end();
    test_random();
    wait_idle();
    if (mismatches == 0) begin
      $display("icon_row_pixel_decoder verification clean");
    end else begin
      $display("icon_row_pixel_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("icon_row_pixel_decoder verification failed");
    $finish;
  end

endmodule
